// ===== sv/cll_pkg.sv =====
// Shared types, field widths and codes for the cursor linked list engine.
// No dependencies; used by cll_ctrl and cursor_linked_list_engine.

package cll_pkg;

	localparam int SLOT_COUNT_DEF = 64;
	localparam int KEY_BITS_DEF   = 32;

	localparam int OP_W     = 2;
	localparam int POS_W    = 6;
	localparam int KEY_IO_W = 32;
	localparam int STATUS_W = 2;
	localparam int SLOT_IO_W = 6;
	localparam int LEN_W    = 6;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]     operation;
		logic [POS_W-1:0]    position;
		logic [KEY_IO_W-1:0] key_in;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [KEY_IO_W-1:0]  key_out;
		logic [SLOT_IO_W-1:0] slot_found;
		logic [LEN_W-1:0]     list_length;
	} res_t;

endpackage

// ===== sv/cll_ram.sv =====
// Single write port, single registered read port memory.
// No dependencies; instantiated by cll_ctrl for the link and key stores.

module cll_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/cll_ctrl.sv =====
// Request sequencer: walks the cursor chains one link read per cycle, then
// relinks slots. Depends on cll_pkg and cll_ram.

module cll_ctrl #(
	parameter int SLOT_COUNT = cll_pkg::SLOT_COUNT_DEF,
	parameter int KEY_BITS   = cll_pkg::KEY_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  cll_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_ready,
	output cll_pkg::res_t res
);

	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam int CMP_W  = ((SLOT_W > cll_pkg::POS_W) ? SLOT_W : cll_pkg::POS_W) + 1;
	localparam logic [SLOT_W-1:0] HEAD      = SLOT_W'(SLOT_COUNT - 1);
	localparam logic [SLOT_W-1:0] LAST_FREE = SLOT_W'(SLOT_COUNT - 2);

	localparam logic [3:0] S_INIT     = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_INS_FREE = 4'd2;
	localparam logic [3:0] S_INS_NXT  = 4'd3;
	localparam logic [3:0] S_WALK     = 4'd4;
	localparam logic [3:0] S_INS_W1   = 4'd5;
	localparam logic [3:0] S_INS_W2   = 4'd6;
	localparam logic [3:0] S_DEL_Q    = 4'd7;
	localparam logic [3:0] S_DEL_F    = 4'd8;
	localparam logic [3:0] S_DEL_W    = 4'd9;
	localparam logic [3:0] S_SRCH_HD  = 4'd10;
	localparam logic [3:0] S_SRCH     = 4'd11;
	localparam logic [3:0] S_RES      = 4'd12;

	logic [3:0]                   state_q;
	logic [SLOT_W-1:0]            init_q;
	logic [SLOT_W-1:0]            cur_q;
	logic [SLOT_W-1:0]            cnt_q;
	logic [SLOT_W-1:0]            n_q;
	logic [SLOT_W-1:0]            j_q;
	logic [SLOT_W-1:0]            nfree_q;
	logic [cll_pkg::POS_W-1:0]    rem_q;
	logic [cll_pkg::OP_W-1:0]     op_q;
	logic [KEY_BITS-1:0]          kin_q;
	logic [cll_pkg::STATUS_W-1:0] status_q;
	logic [cll_pkg::KEY_IO_W-1:0] kout_q;
	logic [cll_pkg::SLOT_IO_W-1:0] slot_q;

	logic                link_we;
	logic [SLOT_W-1:0]   link_waddr;
	logic [SLOT_W-1:0]   link_wdata;
	logic [SLOT_W-1:0]   raddr;
	logic [SLOT_W-1:0]   link_rd;
	logic                key_we;
	logic [KEY_BITS-1:0] key_rd;

	logic pos_zero;
	logic ins_bad;
	logic del_bad;

	assign pos_zero = (req.position == '0);
	assign ins_bad  = pos_zero ||
		(CMP_W'(req.position) > (CMP_W'(cnt_q) + CMP_W'(1)));
	assign del_bad  = pos_zero || (CMP_W'(req.position) > CMP_W'(cnt_q));

	cll_ram #(.DEPTH(SLOT_COUNT), .WIDTH(SLOT_W)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (raddr),
		.rdata (link_rd)
	);

	cll_ram #(.DEPTH(SLOT_COUNT), .WIDTH(KEY_BITS)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (j_q),
		.wdata (kin_q),
		.raddr (raddr),
		.rdata (key_rd)
	);

	always_comb begin
		raddr      = '0;
		link_we    = 1'b0;
		link_waddr = '0;
		link_wdata = '0;
		key_we     = 1'b0;
		case (state_q)
			S_INIT: begin
				link_we    = 1'b1;
				link_waddr = init_q;
				link_wdata = (init_q < LAST_FREE) ? SLOT_W'(init_q + 1'b1) : '0;
			end
			S_IDLE: begin
				raddr = (req.operation == cll_pkg::OP_INSERT) ? '0 : HEAD;
			end
			S_INS_FREE: begin
				raddr = link_rd;
			end
			S_INS_NXT: begin
				raddr = HEAD;
			end
			S_WALK: begin
				raddr = link_rd;
				if (rem_q == '0 && op_q == cll_pkg::OP_INSERT) begin
					link_we    = 1'b1;
					link_waddr = j_q;
					link_wdata = link_rd;
					key_we     = 1'b1;
				end
			end
			S_INS_W1: begin
				link_we    = 1'b1;
				link_waddr = cur_q;
				link_wdata = j_q;
			end
			S_INS_W2: begin
				link_we    = 1'b1;
				link_waddr = '0;
				link_wdata = nfree_q;
			end
			S_DEL_Q: begin
				link_we    = 1'b1;
				link_waddr = cur_q;
				link_wdata = link_rd;
			end
			S_DEL_F: begin
				link_we    = 1'b1;
				link_waddr = j_q;
				link_wdata = link_rd;
			end
			S_DEL_W: begin
				link_we    = 1'b1;
				link_waddr = '0;
				link_wdata = j_q;
			end
			S_SRCH_HD: begin
				raddr = link_rd;
			end
			S_SRCH: begin
				raddr = link_rd;
			end
			default: begin
				raddr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_q  <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_INIT: begin
					init_q <= SLOT_W'(init_q + 1'b1);
					if (init_q == HEAD) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						op_q     <= req.operation;
						kin_q    <= KEY_BITS'($signed(req.key_in));
						cur_q    <= HEAD;
						rem_q    <= req.position - 1'b1;
						kout_q   <= '0;
						slot_q   <= '0;
						status_q <= cll_pkg::ST_OK;
						case (req.operation)
							cll_pkg::OP_INSERT: begin
								if (ins_bad) begin
									status_q <= cll_pkg::ST_BAD_POS;
									state_q  <= S_RES;
								end else begin
									state_q <= S_INS_FREE;
								end
							end
							cll_pkg::OP_DELETE: begin
								if (del_bad) begin
									status_q <= cll_pkg::ST_BAD_POS;
									state_q  <= S_RES;
								end else begin
									state_q <= S_WALK;
								end
							end
							cll_pkg::OP_SEARCH: begin
								state_q <= S_SRCH_HD;
							end
							default: begin
								status_q <= cll_pkg::ST_BAD_POS;
								state_q  <= S_RES;
							end
						endcase
					end
				end
				S_INS_FREE: begin
					if (link_rd == '0) begin
						status_q <= cll_pkg::ST_FULL;
						state_q  <= S_RES;
					end else begin
						j_q     <= link_rd;
						state_q <= S_INS_NXT;
					end
				end
				S_INS_NXT: begin
					nfree_q <= link_rd;
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (rem_q == '0) begin
						if (op_q == cll_pkg::OP_INSERT) begin
							state_q <= S_INS_W1;
						end else begin
							j_q     <= link_rd;
							state_q <= S_DEL_Q;
						end
					end else begin
						cur_q <= link_rd;
						rem_q <= rem_q - 1'b1;
					end
				end
				S_INS_W1: begin
					state_q <= S_INS_W2;
				end
				S_INS_W2: begin
					cnt_q   <= SLOT_W'(cnt_q + 1'b1);
					state_q <= S_RES;
				end
				S_DEL_Q: begin
					kout_q  <= cll_pkg::KEY_IO_W'($signed(key_rd));
					state_q <= S_DEL_F;
				end
				S_DEL_F: begin
					state_q <= S_DEL_W;
				end
				S_DEL_W: begin
					cnt_q   <= SLOT_W'(cnt_q - 1'b1);
					state_q <= S_RES;
				end
				S_SRCH_HD: begin
					n_q      <= '0;
					cur_q    <= link_rd;
					status_q <= cll_pkg::ST_NOT_FOUND;
					if (cnt_q == '0 || link_rd == '0) begin
						state_q <= S_RES;
					end else begin
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					if (key_rd == kin_q) begin
						status_q <= cll_pkg::ST_OK;
						slot_q   <= cll_pkg::SLOT_IO_W'(cur_q);
						state_q  <= S_RES;
					end else if (SLOT_W'(n_q + 1'b1) >= cnt_q || link_rd == '0) begin
						state_q <= S_RES;
					end else begin
						n_q   <= SLOT_W'(n_q + 1'b1);
						cur_q <= link_rd;
					end
				end
				S_RES: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready       = (state_q == S_IDLE);
	assign res_valid       = (state_q == S_RES);
	assign res.status      = status_q;
	assign res.key_out     = kout_q;
	assign res.slot_found  = slot_q;
	assign res.list_length = cll_pkg::LEN_W'(cnt_q);

endmodule

// ===== sv/cursor_linked_list_engine.sv =====
// Ordered key list in a fixed slot array with an internal free chain, one
// request at a time. An insert or a delete walks down the list to its
// position, reading one link per cycle from the link memory; a search walks
// up to list length slots, one slot compared per cycle. A bad position or an
// unknown operation goes straight to the result; a full store is found on the
// free chain head read. After reset a clearing pass over all SLOT_COUNT slots
// builds the free chain, and no request is taken until it ends. The result
// sits in an output register, so a request finishes while the previous result
// still waits.
// Depends on cll_pkg and cll_ctrl.

module cursor_linked_list_engine #(
	parameter int SLOT_COUNT = cll_pkg::SLOT_COUNT_DEF,
	parameter int KEY_BITS   = cll_pkg::KEY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // position[5:0], key_in[37:6], zero fill
	input  logic [1:0]  s_axis_tuser,  // operation[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // key_out[31:0], slot_found[37:32],
	                                   // list_length[43:38], zero fill
	output logic [1:0]  m_axis_tuser   // status[1:0]
);

	cll_pkg::req_t req;
	cll_pkg::res_t res;
	cll_pkg::res_t out_q;
	logic          out_valid_q;
	logic          res_valid;
	logic          res_ready;

	assign req.operation = s_axis_tuser;
	assign req.position  = s_axis_tdata[5:0];
	assign req.key_in    = s_axis_tdata[37:6];

	cll_ctrl #(.SLOT_COUNT(SLOT_COUNT), .KEY_BITS(KEY_BITS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {4'b0000, out_q.list_length, out_q.slot_found, out_q.key_out};

endmodule

// ===== tb/cursor_linked_list_engine_tb.sv =====
// Self-checking testbench for cursor_linked_list_engine: directed table, then random
// insert/delete/search traffic checked against a built-in list predictor.
// Depends on cll_pkg and the engine RTL.

module cursor_linked_list_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [cll_pkg::OP_W-1:0] OP_INVALID = 2'd3;
	localparam logic [cll_pkg::POS_W-1:0] HEAD_SLOT =
		cll_pkg::POS_W'(cll_pkg::SLOT_COUNT_DEF - 1);
	localparam logic [cll_pkg::POS_W-1:0] FREE_HEAD = '0;
	localparam int RAND_ITEMS   = 530;
	localparam int PRESSURE_AT  = 200;
	localparam int PRESSURE_LEN = 400;
	localparam int QUIET_LO     = 260;
	localparam int QUIET_HI     = 320;
	localparam int DRAIN_CYCLES = 150;

	typedef struct packed {
		logic [cll_pkg::OP_W-1:0]     op;
		logic [cll_pkg::POS_W-1:0]    pos;
		logic [cll_pkg::KEY_IO_W-1:0] key;
		logic                         typed;
		cll_pkg::res_t                res;
	} dir_row_t;

	localparam int DIR_N = 23;
	localparam dir_row_t DIR_TAB [DIR_N] = '{
		'{cll_pkg::OP_SEARCH, 6'd0, 32'h0000_0000, 1'b1,
			'{cll_pkg::ST_NOT_FOUND, 32'h0, 6'd0, 6'd0}},
		'{cll_pkg::OP_DELETE, 6'd1, 32'h0000_0000, 1'b1,
			'{cll_pkg::ST_BAD_POS, 32'h0, 6'd0, 6'd0}},
		'{cll_pkg::OP_INSERT, 6'd0, 32'h0000_0005, 1'b1,
			'{cll_pkg::ST_BAD_POS, 32'h0, 6'd0, 6'd0}},
		'{cll_pkg::OP_INSERT, 6'd2, 32'h0000_0005, 1'b1,
			'{cll_pkg::ST_BAD_POS, 32'h0, 6'd0, 6'd0}},
		'{cll_pkg::OP_INSERT, 6'd1, 32'h8000_0000, 1'b1,
			'{cll_pkg::ST_OK, 32'h0, 6'd0, 6'd1}},
		'{cll_pkg::OP_INSERT, 6'd2, 32'h7FFF_FFFF, 1'b1,
			'{cll_pkg::ST_OK, 32'h0, 6'd0, 6'd2}},
		'{cll_pkg::OP_INSERT, 6'd1, 32'hFFFF_FFFF, 1'b1,
			'{cll_pkg::ST_OK, 32'h0, 6'd0, 6'd3}},
		'{cll_pkg::OP_INSERT, 6'd2, 32'h0000_0000, 1'b1,
			'{cll_pkg::ST_OK, 32'h0, 6'd0, 6'd4}},
		'{OP_INVALID, 6'd1, 32'h0000_0000, 1'b1,
			'{cll_pkg::ST_BAD_POS, 32'h0, 6'd0, 6'd4}},
		'{cll_pkg::OP_SEARCH, 6'd0, 32'h7FFF_FFFF, 1'b0, '0},
		'{cll_pkg::OP_SEARCH, 6'd0, 32'h1234_5678, 1'b1,
			'{cll_pkg::ST_NOT_FOUND, 32'h0, 6'd0, 6'd4}},
		'{cll_pkg::OP_INSERT, 6'd63, 32'h0000_0001, 1'b1,
			'{cll_pkg::ST_BAD_POS, 32'h0, 6'd0, 6'd4}},
		'{cll_pkg::OP_INSERT, 6'd5, 32'h7FFF_FFFF, 1'b1,
			'{cll_pkg::ST_OK, 32'h0, 6'd0, 6'd5}},
		'{cll_pkg::OP_SEARCH, 6'd0, 32'h7FFF_FFFF, 1'b0, '0},
		'{cll_pkg::OP_DELETE, 6'd6, 32'h0000_0000, 1'b1,
			'{cll_pkg::ST_BAD_POS, 32'h0, 6'd0, 6'd5}},
		'{cll_pkg::OP_DELETE, 6'd0, 32'h0000_0000, 1'b1,
			'{cll_pkg::ST_BAD_POS, 32'h0, 6'd0, 6'd5}},
		'{cll_pkg::OP_DELETE, 6'd5, 32'h0000_0000, 1'b0, '0},
		'{cll_pkg::OP_DELETE, 6'd1, 32'h0000_0000, 1'b0, '0},
		'{cll_pkg::OP_INSERT, 6'd1, 32'hAAAA_AAAA, 1'b0, '0},
		'{cll_pkg::OP_SEARCH, 6'd0, 32'hAAAA_AAAA, 1'b0, '0},
		'{cll_pkg::OP_SEARCH, 6'd0, 32'h0000_0000, 1'b0, '0},
		'{cll_pkg::OP_DELETE, 6'd4, 32'h0000_0000, 1'b0, '0},
		'{OP_INVALID, 6'd63, 32'hFFFF_FFFF, 1'b1,
			'{cll_pkg::ST_BAD_POS, 32'h0, 6'd0, 6'd3}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;  // position[5:0], key_in[37:6], zero fill
	logic [1:0]  s_axis_tuser = '0;  // operation[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b1;
	logic [47:0] m_axis_tdata;       // key_out[31:0], slot_found[37:32], list_length[43:38]
	logic [1:0]  m_axis_tuser;       // status[1:0]

	logic [cll_pkg::POS_W-1:0]    link_mem [cll_pkg::SLOT_COUNT_DEF];
	logic [cll_pkg::KEY_IO_W-1:0] key_mem [cll_pkg::SLOT_COUNT_DEF];
	int unsigned                  n_keys;
	cll_pkg::res_t                pending_results [$];
	int unsigned                  fail_count = 0;
	logic [cll_pkg::KEY_IO_W-1:0] key_pool [8];

	cursor_linked_list_engine DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Applies one request to the shadow list and returns the result it gives.
	function automatic cll_pkg::res_t list_op_result(logic [cll_pkg::OP_W-1:0] op,
			logic [cll_pkg::POS_W-1:0] pos, logic [cll_pkg::KEY_IO_W-1:0] key);
		cll_pkg::res_t             r;
		logic [cll_pkg::POS_W-1:0] prev, slot, cur;
		int unsigned               i;
		logic                      found;
		r = '0;
		r.status = cll_pkg::ST_OK;
		case (op)
			cll_pkg::OP_INSERT: begin
				if (pos == 0 || pos > n_keys + 1) begin
					r.status = cll_pkg::ST_BAD_POS;
				end else if (link_mem[FREE_HEAD] == 0) begin
					r.status = cll_pkg::ST_FULL;
				end else begin
					prev = HEAD_SLOT;
					for (i = 1; i < pos; i++)
						prev = link_mem[prev];
					slot = link_mem[FREE_HEAD];
					link_mem[FREE_HEAD] = link_mem[slot];
					link_mem[slot] = link_mem[prev];
					link_mem[prev] = slot;
					key_mem[slot] = key;
					n_keys++;
				end
			end
			cll_pkg::OP_DELETE: begin
				if (pos == 0 || pos > n_keys) begin
					r.status = cll_pkg::ST_BAD_POS;
				end else begin
					prev = HEAD_SLOT;
					for (i = 1; i < pos; i++)
						prev = link_mem[prev];
					slot = link_mem[prev];
					r.key_out = key_mem[slot];
					link_mem[prev] = link_mem[slot];
					link_mem[slot] = link_mem[FREE_HEAD];
					link_mem[FREE_HEAD] = slot;
					n_keys--;
				end
			end
			cll_pkg::OP_SEARCH: begin
				r.status = cll_pkg::ST_NOT_FOUND;
				found = 1'b0;
				cur = link_mem[HEAD_SLOT];
				for (i = 0; i < n_keys && cur != 0 && !found; i++) begin
					if (key_mem[cur] == key) begin
						found = 1'b1;
						r.status = cll_pkg::ST_OK;
						r.slot_found = cur;
					end else begin
						cur = link_mem[cur];
					end
				end
			end
			default: r.status = cll_pkg::ST_BAD_POS;
		endcase
		r.list_length = n_keys[cll_pkg::LEN_W-1:0];
		return r;
	endfunction

	task automatic offer_request(input logic [cll_pkg::OP_W-1:0] op,
			input logic [cll_pkg::POS_W-1:0] pos, input logic [cll_pkg::KEY_IO_W-1:0] key,
			input int unsigned gap, input logic typed, input cll_pkg::res_t typed_res);
		cll_pkg::res_t predicted;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, key, pos};
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		predicted = list_op_result(op, pos, key);
		pending_results.push_back(typed ? typed_res : predicted);
	endtask

	initial begin : stimulus
		int unsigned                  k, i, pick, target;
		logic                         growing;
		logic [cll_pkg::OP_W-1:0]     op;
		logic [cll_pkg::POS_W-1:0]    pos, cur;
		logic [cll_pkg::KEY_IO_W-1:0] key;

		for (i = 0; i < cll_pkg::SLOT_COUNT_DEF; i++) begin
			link_mem[i] = (i + 1 < cll_pkg::SLOT_COUNT_DEF - 1) ?
				cll_pkg::POS_W'(i + 1) : '0;
			key_mem[i] = '0;
		end
		link_mem[HEAD_SLOT] = '0;
		n_keys = 0;
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'hFFFF_FFFF;
		key_pool[3] = 32'h0000_0000;
		for (i = 4; i < 8; i++)
			key_pool[i] = $urandom;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < DIR_N; k++)
			offer_request(DIR_TAB[k].op, DIR_TAB[k].pos, DIR_TAB[k].key, idle_len(),
				DIR_TAB[k].typed, DIR_TAB[k].res);

		// Alternate between filling the store up to full and draining it to empty.
		growing = 1'b1;
		for (k = 0; k < RAND_ITEMS; k++) begin
			if (growing && n_keys == cll_pkg::SLOT_COUNT_DEF - 2 && $urandom_range(3) == 0)
				growing = 1'b0;
			else if (!growing && n_keys == 0 && $urandom_range(3) == 0)
				growing = 1'b1;
			pick = $urandom_range(99);
			if (pick < 4)
				op = OP_INVALID;
			else if (pick < 24)
				op = cll_pkg::OP_SEARCH;
			else if ((pick < 86) == growing)
				op = cll_pkg::OP_INSERT;
			else
				op = cll_pkg::OP_DELETE;

			if ($urandom_range(99) < 15 || op == cll_pkg::OP_SEARCH || op == OP_INVALID)
				pos = cll_pkg::POS_W'($urandom_range(63));
			else if (op == cll_pkg::OP_INSERT)
				pos = cll_pkg::POS_W'($urandom_range(n_keys + 1, 1));
			else
				pos = cll_pkg::POS_W'($urandom_range(n_keys > 0 ? n_keys : 1, 1));

			if (op == cll_pkg::OP_SEARCH && n_keys > 0 && $urandom_range(99) < 60) begin
				target = $urandom_range(n_keys, 1);
				cur = link_mem[HEAD_SLOT];
				for (i = 1; i < target; i++)
					cur = link_mem[cur];
				key = key_mem[cur];
			end else if ($urandom_range(99) < 40) begin
				key = key_pool[$urandom_range(7)];
			end else begin
				key = $urandom;
			end

			offer_request(op, pos, key, (k >= QUIET_LO && k < QUIET_HI) ? 0 : idle_len(),
				1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin : result_sink
		int unsigned   n_res, stall;
		cll_pkg::res_t got, want;
		n_res = 0;
		forever begin
			if (n_res == PRESSURE_AT)
				stall = PRESSURE_LEN;
			else if (n_res >= QUIET_LO && n_res < QUIET_HI)
				stall = 0;
			else
				stall = idle_len();
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
				m_axis_tready <= 1'b1;
			end
			do @(posedge clk); while (!m_axis_tvalid);
			got.status      = m_axis_tuser;
			got.key_out     = m_axis_tdata[31:0];
			got.slot_found  = m_axis_tdata[37:32];
			got.list_length = m_axis_tdata[43:38];
			if (pending_results.size() == 0) begin
				$display("%t: unexpected transfer, status %0d key_out %h", $time,
					got.status, got.key_out);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status) begin
					$display("%t: status expected %0d actual %0d", $time,
						want.status, got.status);
					fail_count++;
				end
				if (got.key_out !== want.key_out) begin
					$display("%t: key_out expected %h actual %h", $time,
						want.key_out, got.key_out);
					fail_count++;
				end
				if (got.slot_found !== want.slot_found) begin
					$display("%t: slot_found expected %0d actual %0d", $time,
						want.slot_found, got.slot_found);
					fail_count++;
				end
				if (got.list_length !== want.list_length) begin
					$display("%t: list_length expected %0d actual %0d", $time,
						want.list_length, got.list_length);
					fail_count++;
				end
			end
			n_res++;
		end
	end

endmodule
